### rtl/llh_pkg.sv
// Shared types and constants for the log-linear latency histogram.
package llh_pkg;

  // Widest bin address over the supported bin counts
  localparam int IDX_MAX_W = 10;
  // Fixed widths of the result fields
  localparam int OUT_IDX_W = 9;
  localparam int OUT_CNT_W = 32;
  // Entries in the queue between classifier and counter store
  localparam int QUEUE_DEPTH = 4;

  // Item kinds; the remaining code is unused and yields an all-zero result
  typedef enum logic [1:0] {
    KIND_SEND = 2'd0,
    KIND_RECV = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  // One classified operation for the counter store
  typedef struct packed {
    logic [1:0]           kind;
    logic [IDX_MAX_W-1:0] addr;
    logic [OUT_IDX_W-1:0] out_idx;
    logic                 addr_ok;
  } llh_op_t;

endpackage

### rtl/llh_front.sv
// Front end: reference tracking, delta and log-linear bin classification.
module llh_front
  import llh_pkg::*;
#(
  parameter int BIN_COUNT = 512,
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_take,
  input  logic [1:0]           in_kind,
  input  logic [TIME_BITS-1:0] in_time_ns,
  input  logic [OUT_IDX_W-1:0] in_read_bin,
  input  logic                 q_full,
  output logic                 front_open,
  output logic                 push,
  output llh_op_t              push_op
);

  localparam int NCH  = (TIME_BITS + 7) / 8;
  localparam int PADW = NCH * 8;
  localparam int PW   = $clog2(PADW);
  localparam int CW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int RW   = IDX_MAX_W + 1;

  logic                 en;

  logic [TIME_BITS-1:0] ref_time_r;
  logic                 ref_valid_r;
  logic [TIME_BITS-1:0] in_delta;

  logic                 s1_v_r;
  logic [1:0]           s1_kind_r;
  logic [PADW-1:0]      s1_delta_r;
  logic                 s1_noref_r;
  logic [OUT_IDX_W-1:0] s1_read_bin_r;

  logic                 s2_v_r;
  logic [1:0]           s2_kind_r;
  logic [PADW-1:0]      s2_delta_r;
  logic                 s2_noref_r;
  logic [OUT_IDX_W-1:0] s2_read_bin_r;
  logic                 s2_nz_r  [NCH];
  logic [2:0]           s2_pos_r [NCH];
  logic                 s2_nz_nxt  [NCH];
  logic [2:0]           s2_pos_nxt [NCH];

  logic                 s3_v_r;
  logic [1:0]           s3_kind_r;
  logic [PADW-1:0]      s3_delta_r;
  logic                 s3_noref_r;
  logic [OUT_IDX_W-1:0] s3_read_bin_r;
  logic                 s3_nz_r;
  logic [PW-1:0]        s3_p_r;
  logic                 s3_nz_nxt;
  logic [PW-1:0]        s3_p_nxt;

  logic                 s4_v_r;
  llh_op_t              s4_op_r;
  llh_op_t              s4_op_nxt;

  // Whole pipeline moves unless the last stage is blocked by a full queue
  assign en         = !s4_v_r || !q_full;
  assign front_open = en;
  assign push       = s4_v_r && !q_full;
  assign push_op    = s4_op_r;

  // Delta wraps at the timestamp width
  assign in_delta   = in_time_ns - ref_time_r;

  // Hold the reference timestamp from the latest send mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
    end else if (in_take && in_kind == KIND_SEND) begin
      ref_valid_r <= 1'b1;
    end
    if (in_take && in_kind == KIND_SEND) begin
      ref_time_r <= in_time_ns;
    end
  end

  // Per-byte nonzero flag and leading-one position
  always_comb begin
    logic [7:0] chunk;
    for (int c = 0; c < NCH; c++) begin
      chunk         = s1_delta_r[c*8 +: 8];
      s2_nz_nxt[c]  = |chunk;
      s2_pos_nxt[c] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (chunk[b]) begin
          s2_pos_nxt[c] = 3'(b);
        end
      end
    end
  end

  // Pick the highest nonzero byte to get the leading-one position
  always_comb begin
    s3_nz_nxt = 1'b0;
    s3_p_nxt  = '0;
    for (int c = 0; c < NCH; c++) begin
      if (s2_nz_r[c]) begin
        s3_nz_nxt = 1'b1;
        s3_p_nxt  = PW'((CW'(c) * 8) + s2_pos_r[c]);
      end
    end
  end

  // Map the delta to a bin: 8*e + top four bits + round-up on dropped bits
  always_comb begin
    logic [PW-1:0]   e;
    logic [PADW-1:0] shifted;
    logic [PADW-1:0] low_bits;
    logic            sticky;
    logic [RW-1:0]   raw;
    logic [RW-1:0]   bin;
    e        = s3_p_r - PW'(3);
    shifted  = s3_delta_r >> e;
    low_bits = ~({PADW{1'b1}} << e);
    sticky   = |(s3_delta_r & low_bits);
    if (!s3_nz_r || s3_p_r < PW'(3)) begin
      unique case (s3_delta_r[2:0]) inside
        [3'd0:3'd4]: raw = RW'(0);
        3'd5:        raw = RW'(2);
        3'd6:        raw = RW'(4);
        default:     raw = RW'(6);
      endcase
    end else begin
      raw = (RW'(e) << 3) + RW'(shifted[3:0]) + RW'(sticky);
    end
    // Past the last threshold, or no reference yet: last bin
    if (s3_noref_r || raw > RW'(BIN_COUNT - 1)) begin
      bin = RW'(BIN_COUNT - 1);
    end else begin
      bin = raw;
    end

    s4_op_nxt.kind = s3_kind_r;
    case (s3_kind_r)
      KIND_RECV: begin
        s4_op_nxt.addr    = IDX_MAX_W'(bin);
        s4_op_nxt.out_idx = OUT_IDX_W'(bin);
        s4_op_nxt.addr_ok = 1'b1;
      end
      KIND_READ: begin
        s4_op_nxt.addr    = IDX_MAX_W'(s3_read_bin_r);
        s4_op_nxt.out_idx = s3_read_bin_r;
        s4_op_nxt.addr_ok = RW'(s3_read_bin_r) < RW'(BIN_COUNT);
      end
      default: begin
        s4_op_nxt.addr    = '0;
        s4_op_nxt.out_idx = '0;
        s4_op_nxt.addr_ok = 1'b0;
      end
    endcase
  end

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // Advance the stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind_r     <= in_kind;
      s1_delta_r    <= PADW'(in_delta);
      s1_noref_r    <= !ref_valid_r;
      s1_read_bin_r <= in_read_bin;

      s2_kind_r     <= s1_kind_r;
      s2_delta_r    <= s1_delta_r;
      s2_noref_r    <= s1_noref_r;
      s2_read_bin_r <= s1_read_bin_r;
      for (int c = 0; c < NCH; c++) begin
        s2_nz_r[c]  <= s2_nz_nxt[c];
        s2_pos_r[c] <= s2_pos_nxt[c];
      end

      s3_kind_r     <= s2_kind_r;
      s3_delta_r    <= s2_delta_r;
      s3_noref_r    <= s2_noref_r;
      s3_read_bin_r <= s2_read_bin_r;
      s3_nz_r       <= s3_nz_nxt;
      s3_p_r        <= s3_p_nxt;

      s4_op_r       <= s4_op_nxt;
    end
  end

  // A classified receive always addresses an existing bin
  a_recv_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_op.kind == KIND_RECV |-> RW'(push_op.addr) < RW'(BIN_COUNT))
    else $error("receive bin beyond bin count");

endmodule

### rtl/llh_queue.sv
// Short queue that decouples classification from the counter store.
module llh_queue
  import llh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  llh_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output llh_op_t head
);

  localparam int PTRW = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  llh_op_t         slot_r [QUEUE_DEPTH];
  logic [PTRW-1:0] wr_ptr_r;
  logic [PTRW-1:0] rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  assign full       = cnt_r == CNTW'(QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = slot_r[rd_ptr_r];

  // Track pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue pop while empty");

endmodule

### rtl/llh_back.sv
// Back end: bin counter memory with clearing pass, saturating update and reads.
module llh_back
  import llh_pkg::*;
#(
  parameter int BIN_COUNT  = 512,
  parameter int COUNT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  llh_op_t              q_head,
  output logic                 q_pop,
  output logic                 clearing,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] out_bin_index,
  output logic [OUT_CNT_W-1:0] out_count
);

  localparam int IDXW = $clog2(BIN_COUNT);

  logic [COUNT_BITS-1:0] mem [BIN_COUNT];

  logic                  clr_busy_r;
  logic [IDXW-1:0]       clr_addr_r;

  logic                  b1_v_r;
  llh_op_t               b1_op_r;
  logic [COUNT_BITS-1:0] rd_r;
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_val_r;

  logic                  out_v_r;
  logic [OUT_IDX_W-1:0]  out_idx_r;
  logic [OUT_CNT_W-1:0]  out_cnt_r;

  logic                  b1_adv;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  wr_en;
  logic [IDXW-1:0]       wr_addr;
  logic [IDXW-1:0]       rd_addr;

  assign clearing      = clr_busy_r;
  assign out_valid     = out_v_r;
  assign out_bin_index = out_idx_r;
  assign out_count     = out_cnt_r;

  assign b1_adv  = b1_v_r && (!out_v_r || !out_stall);
  assign q_pop   = q_valid && !clr_busy_r && (!b1_v_r || b1_adv);
  assign rd_addr = q_head.addr[IDXW-1:0];
  assign wr_addr = b1_op_r.addr[IDXW-1:0];

  // Saturating increment on the forwarded or freshly read count
  assign cur   = fwd_hit_r ? fwd_val_r : rd_r;
  assign inc   = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + 1'b1;
  assign wr_en = b1_adv && b1_op_r.kind == KIND_RECV;

  always_comb begin
    case (b1_op_r.kind)
      KIND_RECV: cnt_nxt = inc;
      KIND_READ: cnt_nxt = b1_op_r.addr_ok ? cur : '0;
      default:   cnt_nxt = '0;
    endcase
  end

  // Sweep the memory to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == IDXW'(BIN_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= inc;
    end
    if (q_pop) begin
      rd_r      <= mem[rd_addr];
      fwd_hit_r <= wr_en && wr_addr == rd_addr;
      fwd_val_r <= inc;
      b1_op_r   <= q_head;
    end
  end

  // Hold the operation in flight and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        b1_v_r <= 1'b1;
      end else if (b1_adv) begin
        b1_v_r <= 1'b0;
      end
      if (b1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
    if (b1_adv) begin
      out_idx_r <= b1_op_r.out_idx;
      out_cnt_r <= OUT_CNT_W'(cnt_nxt);
    end
  end

  a_recv_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> inc != '0)
    else $error("updated bin count is zero");

  a_no_update_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !b1_v_r && !out_v_r)
    else $error("operation in flight during clearing pass");

endmodule

### rtl/latency_log_linear_histogram_unit.sv
// Path: input to result runs through 4 classify stages, the queue and
// the counter read/update, and is held up while the result side stalls.
// Throughput: one item per cycle while in_stall is low; back-to-back updates
// of one bin are forwarded around the counter memory's registered read port.
// Reset: synchronous; afterwards a clearing pass writes one bin per cycle,
// over all BIN_COUNT bins, and in_stall stays high until it is done.
module latency_log_linear_histogram_unit
  import llh_pkg::*;
#(
  parameter int BIN_COUNT  = 512,
  parameter int COUNT_BITS = 32,
  parameter int TIME_BITS  = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic [TIME_BITS-1:0] in_time_ns,
  input  logic [OUT_IDX_W-1:0] in_read_bin,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_IDX_W-1:0] out_bin_index,
  output logic [OUT_CNT_W-1:0] out_count
);

  logic    front_open;
  logic    clearing;
  logic    in_take;
  logic    push;
  llh_op_t push_op;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  llh_op_t q_head;

  // Refuse transfers while the front is blocked or the store is clearing
  assign in_stall = !front_open || clearing;
  assign in_take  = in_valid && !in_stall;

  llh_front #(
    .BIN_COUNT (BIN_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (in_take),
    .in_kind     (in_kind),
    .in_time_ns  (in_time_ns),
    .in_read_bin (in_read_bin),
    .q_full      (q_full),
    .front_open  (front_open),
    .push        (push),
    .push_op     (push_op)
  );

  llh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  llh_back #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bin_index (out_bin_index),
    .out_count     (out_count)
  );

endmodule

### tb/testbench.sv
// Self-checking testbench for the log-linear latency histogram unit.
`timescale 1ns / 100ps

module testbench
  import llh_pkg::*;
();

  localparam int BINS = 512;
  localparam int TALLY_W = OUT_CNT_W;
  localparam int TIME_W = 48;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [OUT_IDX_W-1:0] idx;
    logic [TALLY_W-1:0]   tally;
  } hist_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_kind;
  logic [TIME_W-1:0]    in_time_ns;
  logic [OUT_IDX_W-1:0] in_read_bin;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUT_IDX_W-1:0] out_bin_index;
  logic [OUT_CNT_W-1:0] out_count;

  // Predictor state: reference timestamp and per-bin tallies
  logic [TIME_W-1:0]  ref_time;
  logic               ref_held;
  logic [TALLY_W-1:0] bin_tally [BINS];

  hist_result_t expected_results [$];
  hist_result_t head_result;
  int           errors;
  int           cycle_count;
  int           gap_pct;
  int           stall_pct;
  logic [8:0]   last_recv_bin;

  latency_log_linear_histogram_unit #(
    .BIN_COUNT (BINS),
    .COUNT_BITS(TALLY_W),
    .TIME_BITS (TIME_W)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_time_ns   (in_time_ns),
    .in_read_bin  (in_read_bin),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_bin_index(out_bin_index),
    .out_count    (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Upper edge of bin i: floor(2^(i/8+2) * (8 + i%8) / 8), all ones when too large
  function automatic logic [63:0] bin_limit(int unsigned i);
    logic [63:0] mant;
    int unsigned sh;
    mant = 64'(8 + i % 8);
    sh = i / 8 + 2;
    if (sh < 3) return mant >> (3 - sh);
    if (sh - 3 > 60) return '1;
    return mant << (sh - 3);
  endfunction

  // First bin whose edge covers the delta; the last bin takes the overflow
  function automatic int unsigned locate_bin(logic [TIME_W-1:0] delta);
    for (int unsigned i = 0; i + 1 < BINS; i++) begin
      if (64'(delta) <= bin_limit(i)) return i;
    end
    return BINS - 1;
  endfunction

  // Apply one item to the predicted histogram and return its result
  function automatic hist_result_t histogram_update(logic [1:0] kind,
                                                    logic [TIME_W-1:0] t,
                                                    logic [8:0] rb);
    hist_result_t r;
    int unsigned b;
    r.idx = '0;
    r.tally = '0;
    case (kind)
      KIND_SEND: begin
        ref_time = t;
        ref_held = 1'b1;
      end
      KIND_RECV: begin
        b = ref_held ? locate_bin(t - ref_time) : BINS - 1;
        if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1'b1;
        r.idx = b[8:0];
        r.tally = bin_tally[b];
        last_recv_bin = b[8:0];
      end
      KIND_READ: begin
        r.idx = rb;
        if (rb < BINS) r.tally = bin_tally[rb];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Send one item, with an optional idle burst first; predict on transfer
  task automatic send_item(logic [1:0] kind, logic [TIME_W-1:0] t, logic [8:0] rb);
    logic stalled;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_time_ns <= t;
    in_read_bin <= rb;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    expected_results.push_back(histogram_update(kind, t, rb));
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Receive before any send lands in the last bin; unused kind yields zeros
  task automatic test_no_reference();
    send_item(KIND_RECV, 48'h0000_0000_1234, 9'd0);
    send_item(KIND_RECV, '1, '1);
    send_item(KIND_READ, '0, 9'd511);
    send_item(KIND_UNUSED, '1, '1);
    send_item(KIND_READ, '1, 9'd0);
  endtask

  // Deltas on and just past bin edges, plus the largest delta
  task automatic test_bin_edges();
    logic [TIME_W-1:0] base;
    base = 48'h0000_0001_0000;
    send_item(KIND_SEND, base, '1);
    send_item(KIND_RECV, base, 9'd0);
    send_item(KIND_RECV, base + 48'd4, 9'd0);
    send_item(KIND_RECV, base + 48'd5, 9'd0);
    send_item(KIND_RECV, base + 48'd7, 9'd0);
    send_item(KIND_RECV, base + 48'd8, 9'd0);
    send_item(KIND_RECV, base + 48'd9, 9'd0);
    send_item(KIND_RECV, base + TIME_W'(bin_limit(100)), 9'd0);
    send_item(KIND_RECV, base + TIME_W'(bin_limit(100)) + 1'b1, 9'd0);
    send_item(KIND_RECV, base + TIME_W'(bin_limit(367)), 9'd0);
    send_item(KIND_RECV, base - 1'b1, 9'd0);
    send_item(KIND_READ, '0, 9'd0);
    send_item(KIND_READ, '0, 9'd8);
  endtask

  // Delta wraps at the timestamp width; reference survives receives
  task automatic test_wrap();
    send_item(KIND_SEND, '1 - 48'd2, 9'd0);
    send_item(KIND_RECV, 48'd5, 9'd0);
    send_item(KIND_SEND, '1, 9'd0);
    send_item(KIND_RECV, '1, 9'd0);
    send_item(KIND_RECV, '1, 9'd0);
  endtask

  // Back-to-back updates of one bin and an immediate read of it
  task automatic test_back_to_back();
    send_item(KIND_SEND, 48'd1000, 9'd0);
    repeat (4) send_item(KIND_RECV, 48'd1020, 9'd0);
    send_item(KIND_READ, '0, last_recv_bin);
    send_item(KIND_RECV, 48'd1020, 9'd0);
  endtask

  // Mostly receives with log-spread deltas, some sends, reads and noise
  task automatic test_random(int n_items, int gaps, int stalls);
    int pick;
    int unsigned w;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] prev_delta;
    gap_pct = gaps;
    stall_pct = stalls;
    prev_delta = '0;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_item(KIND_SEND, rand_time(), 9'($urandom));
      end else if (pick < 72) begin
        if ($urandom_range(0, 6) == 0) begin
          send_item(KIND_RECV, rand_time(), 9'($urandom));
        end else begin
          if ($urandom_range(0, 4) == 0) begin
            delta = prev_delta;
          end else begin
            w = $urandom_range(0, TIME_W);
            delta = rand_time() & ((48'd1 << w) - 1'b1);
          end
          prev_delta = delta;
          send_item(KIND_RECV, ref_time + delta, 9'($urandom));
        end
      end else if (pick < 94) begin
        send_item(KIND_READ, rand_time(),
                  $urandom_range(0, 1) ? last_recv_bin : 9'($urandom));
      end else begin
        send_item(KIND_UNUSED, rand_time(), 9'($urandom));
      end
    end
  endtask

  // Drive result-side stall in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: bin_index %0d, count %0d",
                 $time, out_bin_index, out_count);
        errors++;
      end else begin
        head_result = expected_results.pop_front();
        if (out_bin_index !== head_result.idx) begin
          $display("%0t: bin_index mismatch: expected %0d, actual %0d",
                   $time, head_result.idx, out_bin_index);
          errors++;
        end
        if (out_count !== head_result.tally) begin
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, head_result.tally, out_count);
          errors++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    gap_pct = 0;
    stall_pct = 0;
    last_recv_bin = '0;
    ref_time = '0;
    ref_held = 1'b0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_SEND;
    in_time_ns <= '0;
    in_read_bin <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_no_reference();
    test_bin_edges();
    test_wrap();
    test_back_to_back();
    test_random(600, 30, 25);
    test_random(200, 0, 0);
    test_random(150, 50, 50);
    test_random(150, 0, 0);

    // Drain outstanding results, then allow for stray ones
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
